// ===== design/owtr_pkg.sv =====
// ----------------------------------------------------------------------------
// owtr_pkg
// shared types and constants of the one-wire temperature reader
// ----------------------------------------------------------------------------
package owtr_pkg;

    localparam int WAIT_LEN_W   = 20;
    localparam int CFG_DATA_W   = 20;
    localparam int CFG_INDEX_W  = 3;

    // sequence stages
    localparam logic [3:0] ST_RESET1  = 4'd0;
    localparam logic [3:0] ST_SETTLE1 = 4'd1;
    localparam logic [3:0] ST_WRITE1  = 4'd2;
    localparam logic [3:0] ST_CONVERT = 4'd3;
    localparam logic [3:0] ST_RESET2  = 4'd4;
    localparam logic [3:0] ST_SETTLE2 = 4'd5;
    localparam logic [3:0] ST_WRITE2  = 4'd6;
    localparam logic [3:0] ST_READ    = 4'd7;

    // slot phases
    localparam logic [2:0] PH_LOW    = 3'd0;
    localparam logic [2:0] PH_SAMPLE = 3'd1;
    localparam logic [2:0] PH_TAIL   = 3'd2;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_SETTLE_WAIT    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_CONVERT_WAIT   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_RESET_LOW      = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_PRESENCE_SMPL  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_RESET_RECOVERY = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_SKIP_ROM       = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_CONVERT_CODE   = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_READ_CODE      = 3'd7;

    // slot timing in ticks
    localparam logic [WAIT_LEN_W-1:0] SLOT_US           = 20'd60;
    localparam logic [WAIT_LEN_W-1:0] WRITE_ONE_LOW_US  = 20'd1;
    localparam logic [WAIT_LEN_W-1:0] WRITE_RECOVERY_US = 20'd1;
    localparam logic [WAIT_LEN_W-1:0] READ_LOW_US       = 20'd2;
    localparam logic [WAIT_LEN_W-1:0] READ_SAMPLE_US    = 20'd10;
    localparam logic [WAIT_LEN_W-1:0] READ_TAIL_US      = 20'd50;

    // register reset values
    localparam logic [15:0] SETTLE_WAIT_RST    = 16'd1000;
    localparam logic [19:0] CONVERT_WAIT_RST   = 20'd800000;
    localparam logic [9:0]  RESET_LOW_RST      = 10'd480;
    localparam logic [9:0]  PRESENCE_SMPL_RST  = 10'd100;
    localparam logic [9:0]  RESET_RECOVERY_RST = 10'd380;
    localparam logic [7:0]  SKIP_ROM_RST       = 8'd204;
    localparam logic [7:0]  CONVERT_CODE_RST   = 8'd68;
    localparam logic [7:0]  READ_CODE_RST      = 8'd190;

    typedef struct packed {
        logic [15:0] settle_wait_us;
        logic [19:0] convert_wait_us;
        logic [9:0]  reset_low_us;
        logic [9:0]  presence_sample_us;
        logic [9:0]  reset_recovery_us;
        logic [7:0]  skip_rom_code;
        logic [7:0]  convert_code;
        logic [7:0]  read_code;
    } owtr_cfg_t;

    typedef struct packed {
        logic [3:0]  stage;
        logic [2:0]  slot_phase;
        logic [2:0]  bit_index;
        logic [1:0]  byte_index;
        logic [7:0]  shift_byte;
        logic [7:0]  low_byte;
        logic [15:0] reading;
    } owtr_state_t;

    typedef struct packed {
        logic        drive_low;
        logic [15:0] temp_raw;
        logic        temp_valid;
        logic        presence_error;
    } owtr_result_t;

endpackage

// ===== design/one_wire_temperature_reader.sv =====
// ----------------------------------------------------------------------------
// one_wire_temperature_reader
// a registered result word appears in the cycle after its input is accepted
// throughput: one input word per cycle, held off only while a result waits
// the sequencer state and result are registered once per accepted tick
// reset: sequence returns to the first bus reset, registers to defaults,
// stored reading cleared, no result pending
// ----------------------------------------------------------------------------
module one_wire_temperature_reader #(
    parameter int WAIT_BITS = 20
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              line_level,
    input  logic                              enable,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              drive_low,
    output logic [15:0]                       temp_raw,
    output logic                              temp_valid,
    output logic                              presence_error,
    input  logic                              cfg_we,
    input  logic [owtr_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [owtr_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import owtr_pkg::*;

    owtr_cfg_t            cfg_reg;
    owtr_state_t          state_reg;
    owtr_state_t          state_next;
    logic [WAIT_BITS-1:0] tick_reg;
    logic [WAIT_BITS-1:0] tick_next;
    owtr_result_t         result_reg;
    owtr_result_t         result_next;
    logic                 out_valid_reg;
    logic                 in_fire;

    assign in_ready = !out_valid_reg || out_ready;
    assign in_fire  = in_valid && in_ready;

    // register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.settle_wait_us     <= SETTLE_WAIT_RST;
            cfg_reg.convert_wait_us    <= CONVERT_WAIT_RST;
            cfg_reg.reset_low_us       <= RESET_LOW_RST;
            cfg_reg.presence_sample_us <= PRESENCE_SMPL_RST;
            cfg_reg.reset_recovery_us  <= RESET_RECOVERY_RST;
            cfg_reg.skip_rom_code      <= SKIP_ROM_RST;
            cfg_reg.convert_code       <= CONVERT_CODE_RST;
            cfg_reg.read_code          <= READ_CODE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SETTLE_WAIT:    cfg_reg.settle_wait_us     <= cfg_data[15:0];
                REG_CONVERT_WAIT:   cfg_reg.convert_wait_us    <= cfg_data[19:0];
                REG_RESET_LOW:      cfg_reg.reset_low_us       <= cfg_data[9:0];
                REG_PRESENCE_SMPL:  cfg_reg.presence_sample_us <= cfg_data[9:0];
                REG_RESET_RECOVERY: cfg_reg.reset_recovery_us  <= cfg_data[9:0];
                REG_SKIP_ROM:       cfg_reg.skip_rom_code      <= cfg_data[7:0];
                REG_CONVERT_CODE:   cfg_reg.convert_code       <= cfg_data[7:0];
                REG_READ_CODE:      cfg_reg.read_code          <= cfg_data[7:0];
            endcase
        end
    end

    owtr_step #(
        .WAIT_BITS (WAIT_BITS)
    ) u_step (
        .cfg        (cfg_reg),
        .state      (state_reg),
        .tick       (tick_reg),
        .line_level (line_level),
        .enable     (enable),
        .state_next (state_next),
        .tick_next  (tick_next),
        .result     (result_next)
    );

    // sequencer state and result word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= '0;
            tick_reg      <= '0;
            result_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            state_reg     <= state_next;
            tick_reg      <= tick_next;
            result_reg    <= result_next;
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid      = out_valid_reg;
    assign drive_low      = result_reg.drive_low;
    assign temp_raw       = result_reg.temp_raw;
    assign temp_valid     = result_reg.temp_valid;
    assign presence_error = result_reg.presence_error;

    a_disable_clears: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && !enable |=> state_reg.stage == ST_RESET1 && tick_reg == '0)
        else $error("disabled tick did not clear the sequence");

    a_fire_gives_word: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> out_valid_reg)
        else $error("accepted word produced no result");

    a_reading_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && result_next.temp_valid |=> state_reg.stage == ST_RESET1)
        else $error("sequence did not restart after a reading");

    a_stage_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.stage <= ST_READ)
        else $error("stage left the sequence");

    a_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !in_fire |=> $stable(state_reg) && $stable(tick_reg))
        else $error("state moved without an accepted word");

endmodule

// ===== design/owtr_step.sv =====
// ----------------------------------------------------------------------------
// owtr_step
// next state and result of the bus sequencer for one microsecond tick
// ----------------------------------------------------------------------------
module owtr_step #(
    parameter int WAIT_BITS = 20
) (
    input  owtr_pkg::owtr_cfg_t    cfg,
    input  owtr_pkg::owtr_state_t  state,
    input  logic [WAIT_BITS-1:0]   tick,
    input  logic                   line_level,
    input  logic                   enable,
    output owtr_pkg::owtr_state_t  state_next,
    output logic [WAIT_BITS-1:0]   tick_next,
    output owtr_pkg::owtr_result_t result
);
    import owtr_pkg::*;

    localparam int LW = (WAIT_BITS > WAIT_LEN_W) ? WAIT_BITS : WAIT_LEN_W;

    logic [WAIT_LEN_W-1:0] len_sel;
    logic [LW-1:0]         len_n;
    logic [LW-1:0]         cmax;
    logic [WAIT_BITS-1:0]  tick_inc;
    logic                  done;
    logic                  counting;
    logic [7:0]            code;
    logic                  cur_bit;
    logic [2:0]            bit_inc;
    logic [1:0]            byte_inc;

    // command bit of the current write slot
    always_comb
    begin
        if (state.byte_index == 2'd0)
        begin
            code = cfg.skip_rom_code;
        end
        else if (state.stage == ST_WRITE1)
        begin
            code = cfg.convert_code;
        end
        else
        begin
            code = cfg.read_code;
        end
        cur_bit = code[state.bit_index];
    end

    // length of the running phase
    always_comb
    begin
        counting = 1'b1;
        len_sel  = '0;
        unique case (state.stage)
            ST_RESET1, ST_RESET2:
            begin
                priority if (state.slot_phase == PH_LOW)
                    len_sel = WAIT_LEN_W'(cfg.reset_low_us);
                else if (state.slot_phase == PH_SAMPLE)
                    len_sel = WAIT_LEN_W'(cfg.presence_sample_us);
                else
                    len_sel = WAIT_LEN_W'(cfg.reset_recovery_us);
            end
            ST_SETTLE1, ST_SETTLE2:
                len_sel = WAIT_LEN_W'(cfg.settle_wait_us);
            ST_CONVERT:
                len_sel = cfg.convert_wait_us;
            ST_WRITE1, ST_WRITE2:
            begin
                if (state.slot_phase == PH_LOW)
                    len_sel = cur_bit ? WRITE_ONE_LOW_US : SLOT_US;
                else
                    len_sel = cur_bit ? SLOT_US : WRITE_RECOVERY_US;
            end
            ST_READ:
            begin
                priority if (state.slot_phase == PH_LOW)
                    len_sel = READ_LOW_US;
                else if (state.slot_phase == PH_SAMPLE)
                    len_sel = READ_SAMPLE_US;
                else
                    len_sel = READ_TAIL_US;
            end
            default:
                counting = 1'b0;
        endcase
    end

    // phase end: zero length lasts one tick, long lengths saturate
    always_comb
    begin
        cmax = LW'({WAIT_BITS{1'b1}});
        if (len_sel == '0)
            len_n = LW'(1);
        else
            len_n = LW'(len_sel);
        if (len_n > cmax)
            len_n = cmax;
        tick_inc = tick + WAIT_BITS'(1);
        done     = LW'(tick_inc) >= len_n;
    end

    assign bit_inc  = state.bit_index + 3'd1;
    assign byte_inc = state.byte_index + 2'd1;

    always_comb
    begin
        state_next            = state;
        result                = '0;
        tick_next             = '0;
        if (!enable)
        begin
            state_next.stage      = ST_RESET1;
            state_next.slot_phase = PH_LOW;
            state_next.bit_index  = '0;
            state_next.byte_index = '0;
            state_next.shift_byte = '0;
        end
        else
        begin
            if (counting)
                tick_next = done ? '0 : tick_inc;
            unique case (state.stage)
                ST_RESET1, ST_RESET2:
                begin
                    priority if (state.slot_phase == PH_LOW)
                    begin
                        result.drive_low = 1'b1;
                        if (done)
                            state_next.slot_phase = PH_SAMPLE;
                    end
                    else if (state.slot_phase == PH_SAMPLE)
                    begin
                        if (done)
                        begin
                            state_next.byte_index    = {1'b0, line_level};
                            result.presence_error    = line_level;
                            state_next.slot_phase    = PH_TAIL;
                        end
                    end
                    else
                    begin
                        if (done)
                        begin
                            state_next.slot_phase = PH_LOW;
                            if (state.byte_index == 2'd0)
                                state_next.stage = state.stage + 4'd1;
                            state_next.byte_index = '0;
                        end
                    end
                end
                ST_SETTLE1, ST_SETTLE2:
                begin
                    if (done)
                        state_next.stage = state.stage + 4'd1;
                end
                ST_CONVERT:
                begin
                    if (done)
                        state_next.stage = ST_RESET2;
                end
                ST_WRITE1, ST_WRITE2:
                begin
                    if (state.slot_phase == PH_LOW)
                    begin
                        result.drive_low = 1'b1;
                        if (done)
                            state_next.slot_phase = PH_SAMPLE;
                    end
                    else if (done)
                    begin
                        state_next.slot_phase = PH_LOW;
                        state_next.bit_index  = bit_inc;
                        if (bit_inc == 3'd0)
                        begin
                            state_next.byte_index = byte_inc;
                            if (byte_inc >= 2'd2)
                            begin
                                state_next.byte_index = '0;
                                state_next.stage      = state.stage + 4'd1;
                            end
                        end
                    end
                end
                ST_READ:
                begin
                    priority if (state.slot_phase == PH_LOW)
                    begin
                        result.drive_low = 1'b1;
                        if (done)
                            state_next.slot_phase = PH_SAMPLE;
                    end
                    else if (state.slot_phase == PH_SAMPLE)
                    begin
                        if (done)
                        begin
                            state_next.shift_byte = {line_level, state.shift_byte[7:1]};
                            state_next.slot_phase = PH_TAIL;
                        end
                    end
                    else if (done)
                    begin
                        state_next.slot_phase = PH_LOW;
                        state_next.bit_index  = bit_inc;
                        if (bit_inc == 3'd0)
                        begin
                            if (state.byte_index == 2'd0)
                            begin
                                state_next.low_byte   = state.shift_byte;
                                state_next.byte_index = 2'd1;
                            end
                            else
                            begin
                                state_next.reading    = {state.shift_byte, state.low_byte};
                                result.temp_valid     = 1'b1;
                                state_next.stage      = ST_RESET1;
                                state_next.bit_index  = '0;
                                state_next.byte_index = '0;
                            end
                            state_next.shift_byte = '0;
                        end
                    end
                end
                default:
                begin
                    state_next.stage      = ST_RESET1;
                    state_next.slot_phase = PH_LOW;
                    state_next.bit_index  = '0;
                    state_next.byte_index = '0;
                    state_next.shift_byte = '0;
                end
            endcase
        end
        result.temp_raw = state_next.reading;
    end

endmodule
